// ===== hw/rtl/tfns_pkg.sv =====
// shared types and constants for the triangle face normal and shade pipeline
package tfns_pkg;

    localparam int COORD_WIDTH = 24;
    // differences are brought back to 25-bit range for wide coordinates
    localparam int SCALE_SHIFT = (COORD_WIDTH > 24) ? COORD_WIDTH - 24 : 0;
    localparam int E_W         = COORD_WIDTH + 1 - SCALE_SHIFT;
    localparam int PROD_W      = 2 * E_W;
    localparam int CR_W        = PROD_W + 1;
    localparam int MAG_W       = CR_W;
    localparam int POS_W       = $clog2(MAG_W);
    localparam int M_W         = 30;
    localparam int TOP_BIT     = M_W - 1;
    localparam int SUM_W       = 2 * M_W + 2;
    localparam int LEN_W       = M_W + 1;
    localparam int FRAC_BITS   = 14;
    localparam int Q_W         = FRAC_BITS + 1;
    localparam int NUM_W       = M_W + FRAC_BITS + 1;
    localparam int N_W         = 16;
    localparam int LUM_W       = 8;
    localparam int LUM_SHIFT   = 30;
    localparam int DP_W        = M_W + 1 + E_W;
    localparam int DOT_W       = DP_W + 2;

    // 127.5 / sqrt(5) in q16, and 255 * 2^29
    localparam logic [21:0] LIGHT_K  = 22'd3736845;
    localparam logic [37:0] LUM_BIAS = 38'd136902082560;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z = 2'd2;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] vertex_a_x;
        logic signed [COORD_WIDTH-1:0] vertex_a_y;
        logic signed [COORD_WIDTH-1:0] vertex_a_z;
        logic signed [COORD_WIDTH-1:0] vertex_b_x;
        logic signed [COORD_WIDTH-1:0] vertex_b_y;
        logic signed [COORD_WIDTH-1:0] vertex_b_z;
        logic signed [COORD_WIDTH-1:0] vertex_c_x;
        logic signed [COORD_WIDTH-1:0] vertex_c_y;
        logic signed [COORD_WIDTH-1:0] vertex_c_z;
    } in_t;

    typedef struct packed {
        logic                  facing;
        logic [LUM_W-1:0]      luminance;
        logic signed [N_W-1:0] unit_normal_x;
        logic signed [N_W-1:0] unit_normal_y;
        logic signed [N_W-1:0] unit_normal_z;
    } out_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
    } cam_t;

    typedef struct packed {
        logic [2:0]            neg;
        logic                  zero;
        logic                  facing;
        logic [2:0][M_W-1:0]   m;
    } side_t;

    typedef struct packed {
        side_t                side;
        logic [SUM_W-1:0]     sum;
    } setup_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
        logic       facing;
    } flag_t;

endpackage

// ===== hw/rtl/tfns_setup.sv =====
// edges, cross product, block scaling, squares and back-face dot product
module tfns_setup (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  tfns_pkg::in_t   item,
    input  tfns_pkg::cam_t  cam,
    output logic            out_valid,
    output tfns_pkg::setup_t out
);
    import tfns_pkg::*;

    localparam int STAGES = 7;

    function automatic logic signed [E_W-1:0] scaled_diff(
        input logic signed [COORD_WIDTH-1:0] p,
        input logic signed [COORD_WIDTH-1:0] q
    );
        logic signed [COORD_WIDTH:0] d;
        d = (COORD_WIDTH + 1)'(p) - (COORD_WIDTH + 1)'(q);
        return E_W'(d >>> SCALE_SHIFT);
    endfunction

    logic signed [COORD_WIDTH-1:0] va [3];
    logic signed [COORD_WIDTH-1:0] vb [3];
    logic signed [COORD_WIDTH-1:0] vc [3];
    logic signed [COORD_WIDTH-1:0] vcam [3];

    assign va[0]   = item.vertex_a_x;
    assign va[1]   = item.vertex_a_y;
    assign va[2]   = item.vertex_a_z;
    assign vb[0]   = item.vertex_b_x;
    assign vb[1]   = item.vertex_b_y;
    assign vb[2]   = item.vertex_b_z;
    assign vc[0]   = item.vertex_c_x;
    assign vc[1]   = item.vertex_c_y;
    assign vc[2]   = item.vertex_c_z;
    assign vcam[0] = cam.x;
    assign vcam[1] = cam.y;
    assign vcam[2] = cam.z;

    logic [STAGES-1:0] valid_reg;

    // stage 1: edges and ray
    logic signed [E_W-1:0] e1_next [3], e2_next [3], ray_next [3];
    logic signed [E_W-1:0] e1_reg [3], e2_reg [3], ray1_reg [3];
    // stage 2: cross product
    logic signed [PROD_W-1:0] pa [3], pb [3];
    logic signed [CR_W-1:0]   cr_next [3], cr_reg [3];
    logic signed [E_W-1:0]    ray2_reg [3];
    // stage 3: magnitudes
    logic [MAG_W-1:0]      mag_next [3], mag3_reg [3];
    logic [MAG_W-1:0]      or_next, or_reg;
    logic [2:0]            neg3_reg;
    logic signed [E_W-1:0] ray3_reg [3];
    // stage 4: leading one
    logic [POS_W-1:0]      pos_next, pos_reg;
    logic [MAG_W-1:0]      mag4_reg [3];
    logic [2:0]            neg4_reg;
    logic                  zero4_reg;
    logic signed [E_W-1:0] ray4_reg [3];
    // stage 5: block scaling
    logic [M_W-1:0]        m_next [3], m5_reg [3];
    logic [2:0]            neg5_reg;
    logic                  zero5_reg;
    logic signed [E_W-1:0] ray5_reg [3];
    // stage 6: squares and dot terms
    logic signed [M_W:0]      qv [3];
    logic [2*M_W-1:0]         sq_next [3], sq_reg [3];
    logic signed [DP_W-1:0]   dp_next [3], dp_reg [3];
    logic [M_W-1:0]           m6_reg [3];
    logic [2:0]               neg6_reg;
    logic                     zero6_reg;
    // stage 7: sums
    logic [SUM_W-1:0]         sum_next, sum_reg;
    logic signed [DOT_W-1:0]  dot;
    logic                     facing_reg;
    logic [M_W-1:0]           m7_reg [3];
    logic [2:0]               neg7_reg;
    logic                     zero7_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1_next[i]  = scaled_diff(vb[i], va[i]);
            e2_next[i]  = scaled_diff(vc[i], va[i]);
            ray_next[i] = scaled_diff(va[i], vcam[i]);
        end
    end

    always_comb
    begin
        pa[0] = e1_reg[1] * e2_reg[2];
        pb[0] = e1_reg[2] * e2_reg[1];
        pa[1] = e1_reg[2] * e2_reg[0];
        pb[1] = e1_reg[0] * e2_reg[2];
        pa[2] = e1_reg[0] * e2_reg[1];
        pb[2] = e1_reg[1] * e2_reg[0];
        for (int i = 0; i < 3; i++)
        begin
            cr_next[i] = CR_W'(pa[i]) - CR_W'(pb[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = cr_reg[i][CR_W-1] ? MAG_W'(-cr_reg[i]) : MAG_W'(cr_reg[i]);
        end
        or_next = mag_next[0] | mag_next[1] | mag_next[2];
    end

    always_comb
    begin
        pos_next = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (or_reg[i])
            begin
                pos_next = POS_W'(i);
            end
        end
    end

    // largest magnitude lands with its top bit on TOP_BIT
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (pos_reg >= POS_W'(TOP_BIT))
            begin
                m_next[i] = M_W'(mag4_reg[i] >> (pos_reg - POS_W'(TOP_BIT)));
            end
            else
            begin
                m_next[i] = M_W'(mag4_reg[i] << (POS_W'(TOP_BIT) - pos_reg));
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qv[i]      = neg5_reg[i] ? -$signed({1'b0, m5_reg[i]}) : $signed({1'b0, m5_reg[i]});
            sq_next[i] = m5_reg[i] * m5_reg[i];
            dp_next[i] = qv[i] * ray5_reg[i];
        end
    end

    always_comb
    begin
        sum_next = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        dot      = DOT_W'(dp_reg[0]) + DOT_W'(dp_reg[1]) + DOT_W'(dp_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1_reg[i]   <= e1_next[i];
            e2_reg[i]   <= e2_next[i];
            ray1_reg[i] <= ray_next[i];
            cr_reg[i]   <= cr_next[i];
            ray2_reg[i] <= ray1_reg[i];
            mag3_reg[i] <= mag_next[i];
            ray3_reg[i] <= ray2_reg[i];
            mag4_reg[i] <= mag3_reg[i];
            ray4_reg[i] <= ray3_reg[i];
            m5_reg[i]   <= m_next[i];
            ray5_reg[i] <= ray4_reg[i];
            sq_reg[i]   <= sq_next[i];
            dp_reg[i]   <= dp_next[i];
            m6_reg[i]   <= m5_reg[i];
            m7_reg[i]   <= m6_reg[i];
            neg3_reg[i] <= cr_reg[i][CR_W-1];
        end
        or_reg     <= or_next;
        pos_reg    <= pos_next;
        neg4_reg   <= neg3_reg;
        zero4_reg  <= (or_reg == '0);
        neg5_reg   <= neg4_reg;
        zero5_reg  <= zero4_reg;
        neg6_reg   <= neg5_reg;
        zero6_reg  <= zero5_reg;
        sum_reg    <= sum_next;
        facing_reg <= dot[DOT_W-1];
        neg7_reg   <= neg6_reg;
        zero7_reg  <= zero6_reg;
    end

    assign out_valid          = valid_reg[STAGES-1];
    assign out.side.neg       = neg7_reg;
    assign out.side.zero      = zero7_reg;
    assign out.side.facing    = facing_reg;
    assign out.side.m[0]      = m7_reg[0];
    assign out.side.m[1]      = m7_reg[1];
    assign out.side.m[2]      = m7_reg[2];
    assign out.sum            = sum_reg;

endmodule

// ===== hw/rtl/tfns_isqrt.sv =====
// pipelined integer square root, one result bit per stage
module tfns_isqrt #(
    parameter int SB_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [tfns_pkg::SUM_W-1:0]  radicand,
    input  logic [SB_W-1:0]             in_side,
    output logic                        out_valid,
    output logic [tfns_pkg::LEN_W-1:0]  root,
    output logic [SB_W-1:0]             out_side
);
    import tfns_pkg::*;

    localparam int STEPS = SUM_W / 2;

    logic [STEPS-1:0] valid_reg;
    logic [SUM_W-1:0] rem_reg  [STEPS];
    logic [SUM_W-1:0] res_reg  [STEPS];
    logic [SB_W-1:0]  side_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);

        logic [SUM_W-1:0] rem_in, res_in, trial, rem_next, res_next;
        logic [SB_W-1:0]  side_in;
        logic             valid_in;

        if (k == 0)
        begin : g_first
            assign rem_in   = radicand;
            assign res_in   = '0;
            assign side_in  = in_side;
            assign valid_in = in_valid;
        end
        else
        begin : g_rest
            assign rem_in   = rem_reg[k-1];
            assign res_in   = res_reg[k-1];
            assign side_in  = side_reg[k-1];
            assign valid_in = valid_reg[k-1];
        end

        always_comb
        begin
            trial = res_in + BIT;
            if (rem_in >= trial)
            begin
                rem_next = rem_in - trial;
                res_next = (res_in >> 1) + BIT;
            end
            else
            begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            res_reg[k]  <= res_next;
            side_reg[k] <= side_in;
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign root      = LEN_W'(res_reg[STEPS-1]);
    assign out_side  = side_reg[STEPS-1];

endmodule

// ===== hw/rtl/tfns_divide.sv =====
// three-lane pipelined rounded divider for the normal components
module tfns_divide #(
    parameter int SB_W = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic [tfns_pkg::LEN_W-1:0]          divisor,
    input  logic [2:0][tfns_pkg::M_W-1:0]       m,
    input  logic [SB_W-1:0]                     in_side,
    output logic                                out_valid,
    output logic [2:0][tfns_pkg::Q_W-1:0]       quot,
    output logic [SB_W-1:0]                     out_side
);
    import tfns_pkg::*;

    logic             prep_valid_reg;
    logic [NUM_W-1:0] prep_num_reg [3];
    logic [LEN_W-1:0] prep_den_reg;
    logic [SB_W-1:0]  prep_side_reg;

    logic [Q_W-1:0]   valid_reg;
    logic [NUM_W-1:0] rem_reg  [Q_W][3];
    logic [Q_W-1:0]   q_reg    [Q_W][3];
    logic [LEN_W-1:0] den_reg  [Q_W];
    logic [SB_W-1:0]  side_reg [Q_W];

    // numerator carries half the divisor for round to nearest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else
        begin
            prep_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            prep_num_reg[i] <= NUM_W'({m[i], {FRAC_BITS{1'b0}}}) + NUM_W'(divisor >> 1);
        end
        prep_den_reg  <= divisor;
        prep_side_reg <= in_side;
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        localparam int SH = Q_W - 1 - k;

        logic [NUM_W-1:0] rem_in [3];
        logic [Q_W-1:0]   q_in [3];
        logic [NUM_W-1:0] rem_next [3];
        logic [Q_W-1:0]   q_next [3];
        logic [NUM_W-1:0] dsh;
        logic [LEN_W-1:0] den_in;
        logic [SB_W-1:0]  side_in;
        logic             valid_in;

        if (k == 0)
        begin : g_first
            for (genvar j = 0; j < 3; j++)
            begin : g_lane
                assign rem_in[j] = prep_num_reg[j];
                assign q_in[j]   = '0;
            end
            assign den_in   = prep_den_reg;
            assign side_in  = prep_side_reg;
            assign valid_in = prep_valid_reg;
        end
        else
        begin : g_rest
            for (genvar j = 0; j < 3; j++)
            begin : g_lane
                assign rem_in[j] = rem_reg[k-1][j];
                assign q_in[j]   = q_reg[k-1][j];
            end
            assign den_in   = den_reg[k-1];
            assign side_in  = side_reg[k-1];
            assign valid_in = valid_reg[k-1];
        end

        always_comb
        begin
            dsh = NUM_W'(den_in) << SH;
            for (int i = 0; i < 3; i++)
            begin
                if (rem_in[i] >= dsh)
                begin
                    rem_next[i] = rem_in[i] - dsh;
                    q_next[i]   = {q_in[i][Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = rem_in[i];
                    q_next[i]   = {q_in[i][Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[k][i] <= rem_next[i];
                q_reg[k][i]   <= q_next[i];
            end
            den_reg[k]  <= den_in;
            side_reg[k] <= side_in;
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign quot[0]   = q_reg[Q_W-1][0];
    assign quot[1]   = q_reg[Q_W-1][1];
    assign quot[2]   = q_reg[Q_W-1][2];
    assign out_side  = side_reg[Q_W-1];

endmodule

// ===== hw/rtl/triangle_face_normal_shade_top.sv =====
// top level: camera registers, pipeline chain and shading output stages
//
// Takes one triangle per clock whenever start is high; busy never rises, and a
// result leaves on result with done high for one cycle, in order. Each triangle
// passes through the setup pipeline, the 31-stage square root and the 16-stage
// rounding divider that form the unit normal, and the shading output registers;
// the receiver cannot stall, so every result must be taken as it appears. Camera
// registers are written through the cfg port, which is always ready.
module triangle_face_normal_shade_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  tfns_pkg::in_t                         item,
    output logic                                  done,
    output tfns_pkg::out_t                        result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tfns_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tfns_pkg::COORD_WIDTH-1:0]      cfg_data
);
    import tfns_pkg::*;

    localparam int T_W    = N_W + 2;
    localparam int PL_W   = 23 + T_W;
    localparam int ACC_W  = PL_W + 1;
    localparam int LRAW_W = ACC_W - LUM_SHIFT;

    cam_t  cam_reg;
    logic  in_valid;

    logic   setup_valid;
    setup_t setup_word;
    logic   sq_valid;
    logic [LEN_W-1:0] len;
    side_t  sq_side;
    flag_t  div_flags_in, div_flags;
    logic   div_valid;
    logic [2:0][Q_W-1:0] quot;

    logic                  f1_valid_reg, f2_valid_reg, done_reg;
    logic signed [N_W-1:0] n_next [3], n1_reg [3], n2_reg [3];
    logic [N_W-1:0]        nmag;
    logic signed [T_W-1:0] t_next, t_reg;
    logic                  facing1_reg, facing2_reg;
    logic signed [PL_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0] acc;
    logic signed [LRAW_W-1:0] lum_raw;
    logic [LUM_W-1:0]      lum;
    out_t                  result_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_valid  = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CAMERA_X: cam_reg.x <= cfg_data;
                REG_CAMERA_Y: cam_reg.y <= cfg_data;
                REG_CAMERA_Z: cam_reg.z <= cfg_data;
                default: ;
            endcase
        end
    end

    tfns_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .item      (item),
        .cam       (cam_reg),
        .out_valid (setup_valid),
        .out       (setup_word)
    );

    tfns_isqrt #(
        .SB_W ($bits(side_t))
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (setup_valid),
        .radicand  (setup_word.sum),
        .in_side   (setup_word.side),
        .out_valid (sq_valid),
        .root      (len),
        .out_side  (sq_side)
    );

    assign div_flags_in.neg    = sq_side.neg;
    assign div_flags_in.zero   = sq_side.zero;
    assign div_flags_in.facing = sq_side.facing;

    tfns_divide #(
        .SB_W ($bits(flag_t))
    ) u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .divisor   (len),
        .m         (sq_side.m),
        .in_side   (div_flags_in),
        .out_valid (div_valid),
        .quot      (quot),
        .out_side  (div_flags)
    );

    // signed normal, zero for a degenerate triangle
    always_comb
    begin
        nmag = '0;
        for (int i = 0; i < 3; i++)
        begin
            nmag      = div_flags.zero ? '0 : N_W'(quot[i]);
            n_next[i] = div_flags.neg[i] ? -$signed(nmag) : $signed(nmag);
        end
        t_next = T_W'(n_next[0]) + (T_W'(n_next[1]) <<< 1);
    end

    always_comb
    begin
        acc     = ACC_W'(prod_reg) + $signed(ACC_W'(LUM_BIAS));
        lum_raw = acc[ACC_W-1:LUM_SHIFT];
        priority if (lum_raw < 0)
        begin
            lum = '0;
        end
        else if (lum_raw > LRAW_W'(255))
        begin
            lum = '1;
        end
        else
        begin
            lum = LUM_W'(lum_raw);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= div_valid;
            f2_valid_reg <= f1_valid_reg;
            done_reg     <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            n1_reg[i] <= n_next[i];
            n2_reg[i] <= n1_reg[i];
        end
        t_reg       <= t_next;
        facing1_reg <= div_flags.facing & ~div_flags.zero;
        facing2_reg <= facing1_reg;
        prod_reg    <= $signed({1'b0, LIGHT_K}) * t_reg;
        result_reg.facing        <= facing2_reg;
        result_reg.luminance     <= lum;
        result_reg.unit_normal_x <= n2_reg[0];
        result_reg.unit_normal_y <= n2_reg[1];
        result_reg.unit_normal_z <= n2_reg[2];
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== verif/triangle_face_normal_shade_top_tb.sv =====
// testbench for the triangle face normal and shade pipeline
`timescale 1ns / 100ps

module triangle_face_normal_shade_top_tb;
    import tfns_pkg::*;

    typedef struct {
        in_t  vertices;
        bit   typed;
        out_t shade;
    } tri_row_t;

    localparam int HOLD_CYCLES = 64;
    localparam int EXP_DEPTH   = 2048;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic signed [COORD_WIDTH-1:0] C_MAX = 24'sh7fffff;
    localparam logic signed [COORD_WIDTH-1:0] C_MIN = 24'sh800000;
    localparam logic signed [COORD_WIDTH-1:0] C_ONE = 24'sd256;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_t  item;
    logic done;
    out_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_WIDTH-1:0] cfg_data;

    cam_t cam_model;
    out_t expected_shades [EXP_DEPTH];
    int   n_sent;
    int   n_checked;
    int   n_errors;
    bit   idle_on;

    triangle_face_normal_shade_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic out_t predict_shade(in_t t, cam_t c);
        longint a[3], b[3], cm[3], e1[3], e2[3], ray[3], cr[3], q[3], n[3];
        longint lv[3];
        longint unsigned m[3], mx, sum, len, u;
        longint dotp, acc, lum;
        int rs, ls;
        out_t r;
        a = '{t.vertex_a_x, t.vertex_a_y, t.vertex_a_z};
        b = '{t.vertex_b_x, t.vertex_b_y, t.vertex_b_z};
        lv = '{t.vertex_c_x, t.vertex_c_y, t.vertex_c_z};
        cm = '{c.x, c.y, c.z};
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = b[i] - a[i];
            e2[i] = lv[i] - a[i];
            ray[i] = a[i] - cm[i];
            q[i] = 0;
            n[i] = 0;
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = cr[i] < 0 ? -cr[i] : cr[i];
            if (m[i] > mx)
                mx = m[i];
        end
        r.facing = 1'b0;
        if (mx != 0)
        begin
            rs = 0;
            ls = 0;
            sum = 0;
            while ((mx >> rs) >= (64'd1 << 30))
                rs++;
            while (((mx >> rs) << ls) < (64'd1 << 29))
                ls++;
            for (int i = 0; i < 3; i++)
            begin
                m[i] = (m[i] >> rs) << ls;
                sum += m[i] * m[i];
            end
            len = int_sqrt(sum);
            for (int i = 0; i < 3; i++)
            begin
                u = (m[i] * 16384 + (len >> 1)) / len;
                q[i] = cr[i] < 0 ? -longint'(m[i]) : longint'(m[i]);
                n[i] = cr[i] < 0 ? -longint'(u) : longint'(u);
            end
            dotp = q[0] * ray[0] + q[1] * ray[1] + q[2] * ray[2];
            r.facing = dotp < 0;
        end
        // 255 * 2^29 bias plus the light term, floored by 2^30
        acc = 64'sd136902082560 + 64'sd3736845 * (n[0] + 2 * n[1]);
        lum = acc >>> 30;
        if (lum < 0)
            lum = 0;
        if (lum > 255)
            lum = 255;
        r.luminance = lum[7:0];
        r.unit_normal_x = n[0][15:0];
        r.unit_normal_y = n[1][15:0];
        r.unit_normal_z = n[2][15:0];
        return r;
    endfunction

    task automatic mismatch_report(string what, longint got, longint want);
        $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (n_sent == n_checked)
            begin
                mismatch_report("result count", n_checked + 1, n_sent);
            end
            else
            begin
                out_t w;
                w = expected_shades[n_checked % EXP_DEPTH];
                n_checked++;
                if (result.facing !== w.facing)
                    mismatch_report("facing", result.facing, w.facing);
                if (result.luminance !== w.luminance)
                    mismatch_report("luminance", result.luminance, w.luminance);
                if (result.unit_normal_x !== w.unit_normal_x)
                    mismatch_report("normal x", result.unit_normal_x, w.unit_normal_x);
                if (result.unit_normal_y !== w.unit_normal_y)
                    mismatch_report("normal y", result.unit_normal_y, w.unit_normal_y);
                if (result.unit_normal_z !== w.unit_normal_z)
                    mismatch_report("normal z", result.unit_normal_z, w.unit_normal_z);
            end
        end
    end

    task automatic send_tri(in_t t, bit typed, out_t shade);
        int gap;
        if (idle_on && $urandom_range(3) == 0)
        begin
            gap = $urandom_range(7, 1);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= t;
        start <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        expected_shades[n_sent % EXP_DEPTH] = typed ? shade : predict_shade(t, cam_model);
        n_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_WIDTH-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        cfg_valid <= 1'b0;
        case (idx)
            REG_CAMERA_X: cam_model.x = val;
            REG_CAMERA_Y: cam_model.y = val;
            REG_CAMERA_Z: cam_model.z = val;
            default: ;
        endcase
    endtask

    task automatic drain;
        start <= 1'b0;
        while (n_sent != n_checked)
            @(posedge clk);
        repeat (HOLD_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] rand_coord(bit narrow);
        if (narrow)
            return COORD_WIDTH'($signed($urandom_range(8192)) - 4096);
        return COORD_WIDTH'($urandom);
    endfunction

    function automatic in_t rand_tri();
        in_t t;
        bit narrow;
        narrow = $urandom_range(1);
        t = {rand_coord(narrow), rand_coord(narrow), rand_coord(narrow),
             rand_coord(narrow), rand_coord(narrow), rand_coord(narrow),
             rand_coord(narrow), rand_coord(narrow), rand_coord(narrow)};
        // some special words: repeated vertices, or vertices a and c at the same z
        case ($urandom_range(15))
            0: {t.vertex_b_x, t.vertex_b_y, t.vertex_b_z} =
               {t.vertex_a_x, t.vertex_a_y, t.vertex_a_z};
            1: {t.vertex_c_x, t.vertex_c_y, t.vertex_c_z} =
               {t.vertex_b_x, t.vertex_b_y, t.vertex_b_z};
            2: t.vertex_c_z = t.vertex_a_z;
            default: ;
        endcase
        return t;
    endfunction

    tri_row_t directed[$];
    out_t flat_shade;
    out_t zero_shade;

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_CAMERA_X;
        cfg_data = '0;
        cam_model = '0;
        n_sent = 0;
        n_checked = 0;
        n_errors = 0;
        idle_on = 1'b1;
        zero_shade = '{1'b0, 8'd127, 16'sd0, 16'sd0, 16'sd0};
        flat_shade = '{1'b0, 8'd127, 16'sd0, 16'sd0, 16'sd16384};
        directed = '{
            '{'0, 1'b1, zero_shade},
            '{{9{C_MAX}}, 1'b1, zero_shade},
            '{{9{C_MIN}}, 1'b1, zero_shade},
            '{{24'sd0, 24'sd0, 24'sd0, C_ONE, 24'sd0, 24'sd0, 24'sd0, C_ONE, 24'sd0},
              1'b1, flat_shade},
            '{{24'sd0, 24'sd0, 24'sd0, 24'sd0, C_ONE, 24'sd0, C_ONE, 24'sd0, 24'sd0},
              1'b0, zero_shade},
            '{{C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN},
              1'b0, zero_shade},
            '{{C_MAX, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX},
              1'b0, zero_shade},
            '{{C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN},
              1'b0, zero_shade},
            '{{24'sd0, 24'sd0, 24'sd0, C_ONE, 24'sd0, 24'sd0, C_MAX, 24'sd0, 24'sd0},
              1'b1, zero_shade},
            '{{24'sd0, C_ONE, 24'sd0, 24'sd0, 24'sd0, C_ONE, C_ONE, 24'sd0, 24'sd0},
              1'b0, zero_shade},
            '{{24'sd0, 24'sd0, C_ONE, C_ONE, 24'sd0, 24'sd0, 24'sd0, C_ONE, 24'sd0},
              1'b0, zero_shade},
            '{{24'sd1, 24'sd0, 24'sd0, 24'sd2, 24'sd0, 24'sd0, 24'sd1, 24'sd1, 24'sd0},
              1'b0, zero_shade},
            '{{C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN},
              1'b0, zero_shade}
        };
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_tri(directed[i].vertices, directed[i].typed, directed[i].shade);
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_CAMERA_X, C_MAX);
                    write_reg(REG_CAMERA_Y, C_MIN);
                    write_reg(REG_CAMERA_Z, C_MAX);
                end
                1:
                begin
                    write_reg(REG_CAMERA_X, C_MIN);
                    write_reg(REG_CAMERA_Y, C_MAX);
                    write_reg(REG_CAMERA_Z, C_MIN);
                    write_reg(REG_UNUSED, C_MAX);
                end
                4:
                begin
                    write_reg(REG_CAMERA_X, '0);
                    write_reg(REG_CAMERA_Y, '0);
                    write_reg(REG_CAMERA_Z, '0);
                    idle_on = 1'b0;
                end
                default:
                begin
                    write_reg(REG_CAMERA_X, COORD_WIDTH'($urandom));
                    write_reg(REG_CAMERA_Y, COORD_WIDTH'($urandom));
                    write_reg(REG_CAMERA_Z, COORD_WIDTH'($urandom));
                end
            endcase
            for (int k = 0; k < 267; k++)
                send_tri(rand_tri(), 1'b0, zero_shade);
            drain();
        end

        if (n_errors == 0)
            $display("triangle_face_normal_shade_top test passed");
        else
            $display("triangle_face_normal_shade_top test failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("triangle_face_normal_shade_top test failed");
        $finish;
    end

endmodule
